[rtl/hfds_pkg.sv]
package hfds_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SIDE_DEF    = 256;
  localparam int STORE_WORDS_DEF = 131072;
  localparam int DEPTH_BITS_DEF  = 24;

  // Fixed field widths
  localparam int ADDR_W     = 17;
  localparam int DEPTH_W    = 24;
  localparam int UV_W       = 21;
  localparam int LEVEL_W    = 4;
  localparam int SIDE_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Clamped UV in [0, 1.0] as Q.16
  localparam int UVC_W = 17;
  localparam logic [UVC_W-1:0] UV_ONE = 17'h10000;

  // Linear texel address across the whole pyramid (9-bit sides)
  localparam int RADDR_W = 19;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 2'd2;

  typedef struct packed {
    logic       load;
    logic       wr;
    logic       off_step;
    logic       idx_step;
    logic       row_step;
    logic       rd_issue;
    logic       fold;
    logic       out_load;
    logic [1:0] step;
  } hfds_cmd_t;

  typedef struct packed {
    logic bypass;
    logic off_done;
  } hfds_sts_t;

endpackage

[rtl/hfds_req_if.sv]
interface hfds_req_if import hfds_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [ADDR_W-1:0]         write_address;
  logic [DEPTH_W-1:0]        write_depth;
  logic signed [UV_W-1:0]    rect_min_u;
  logic signed [UV_W-1:0]    rect_max_u;
  logic signed [UV_W-1:0]    rect_min_v;
  logic signed [UV_W-1:0]    rect_max_v;
  logic [LEVEL_W-1:0]        rect_level;
  logic                      rect_testable;

  modport source (
    output valid, req_type, write_address, write_depth,
    output rect_min_u, rect_max_u, rect_min_v, rect_max_v, rect_level, rect_testable,
    input  ready
  );
  modport sink (
    input  valid, req_type, write_address, write_depth,
    input  rect_min_u, rect_max_u, rect_min_v, rect_max_v, rect_level, rect_testable,
    output ready
  );
endinterface

[rtl/hfds_res_if.sv]
interface hfds_res_if import hfds_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] farthest_depth;

  modport source (output valid, farthest_depth, input ready);
  modport sink   (input valid, farthest_depth, output ready);
endinterface

[rtl/hfds_ram.sv]
module hfds_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/hfds_ctrl.sv]
module hfds_ctrl import hfds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_is_write,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output hfds_cmd_t cmd,
  input  hfds_sts_t sts
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OFF  = 3'd1;
  localparam logic [2:0] ST_IDX  = 3'd2;
  localparam logic [2:0] ST_ROW  = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_FOLD = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.step  = step_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_is_write) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            step_nxt  = 2'd0;
            state_nxt = sts.bypass ? ST_DONE : ST_OFF;
          end
        end
      end
      ST_OFF: begin
        if (sts.off_done) begin
          state_nxt = ST_IDX;
          step_nxt  = 2'd0;
        end else begin
          cmd.off_step = 1'b1;
        end
      end
      ST_IDX: begin
        cmd.idx_step = 1'b1;
        step_nxt     = step_r + 2'd1;
        if (step_r == 2'd3) begin
          state_nxt = ST_ROW;
        end
      end
      ST_ROW: begin
        cmd.row_step = 1'b1;
        if (step_r == 2'd1) begin
          step_nxt  = 2'd0;
          state_nxt = ST_RD;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end
      ST_RD: begin
        // read k issues while the data of read k-1 is folded
        cmd.rd_issue = 1'b1;
        cmd.fold     = (step_r != 2'd0);
        step_nxt     = step_r + 2'd1;
        if (step_r == 2'd3) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_fold_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FOLD |=> state_r == ST_DONE)
    else $error("fold not followed by result stage");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && in_is_write) |=> state_r == ST_IDLE)
    else $error("write item left the idle state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before taken");

endmodule

[rtl/hfds_dp.sv]
module hfds_dp import hfds_pkg::*; #(
  parameter int MAX_SIDE    = MAX_SIDE_DEF,
  parameter int STORE_WORDS = STORE_WORDS_DEF,
  parameter int DEPTH_BITS  = DEPTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  hfds_cmd_t              cmd,
  output hfds_sts_t              sts,
  input  logic [ADDR_W-1:0]      write_address,
  input  logic [DEPTH_W-1:0]     write_depth,
  input  logic signed [UV_W-1:0] rect_min_u,
  input  logic signed [UV_W-1:0] rect_max_u,
  input  logic signed [UV_W-1:0] rect_min_v,
  input  logic signed [UV_W-1:0] rect_max_v,
  input  logic [LEVEL_W-1:0]     rect_level,
  input  logic                   rect_testable,
  output logic [DEPTH_W-1:0]     farthest_depth
);

  localparam int AW   = $clog2(STORE_WORDS);
  localparam int RA_W = (AW > RADDR_W) ? AW : RADDR_W;
  localparam int WA_W = (AW > ADDR_W) ? AW : ADDR_W;
  localparam int PROD_W = UVC_W + SIDE_W;

  function automatic logic [SIDE_W-1:0] side_clamp(input logic [SIDE_W-1:0] s);
    if (32'(s) > MAX_SIDE) begin
      return SIDE_W'(MAX_SIDE);
    end
    return s;
  endfunction

  function automatic logic [SIDE_W-1:0] at_least_one(input logic [SIDE_W-1:0] s);
    return (s == '0) ? SIDE_W'(1) : s;
  endfunction

  function automatic logic [UVC_W-1:0] uv_clamp(input logic signed [UV_W-1:0] c);
    if (c < 0) begin
      return '0;
    end
    if (c > $signed({{(UV_W-UVC_W){1'b0}}, UV_ONE})) begin
      return UV_ONE;
    end
    return c[UVC_W-1:0];
  endfunction

  // Configuration
  logic [SIDE_W-1:0]  base_w_r, base_h_r;
  logic [LEVEL_W-1:0] lvl_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_w_r  <= '0;
      base_h_r  <= '0;
      lvl_cnt_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BASE_WIDTH:  base_w_r  <= cfg_wdata;
        CFG_BASE_HEIGHT: base_h_r  <= cfg_wdata;
        CFG_LEVEL_COUNT: lvl_cnt_r <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SIDE_W-1:0] side_w, side_h;
  assign side_w = side_clamp(base_w_r);
  assign side_h = side_clamp(base_h_r);

  assign sts.bypass = (lvl_cnt_r == '0) || (side_w == '0) || (side_h == '0) || !rect_testable;

  // Query working registers
  logic [LEVEL_W-1:0] mip_r, lv_r;
  logic [RADDR_W-1:0] offset_r;
  logic [UVC_W-1:0]   cu_r [4];   // min_u, max_u, min_v, max_v
  logic [SIDE_W-1:0]  xy_r [4];   // x0, x1, y0, y1
  logic [2*SIDE_W-1:0] row_r [2];
  logic [DEPTH_BITS-1:0] best_r;
  logic                  oor_r;
  logic [DEPTH_W-1:0]    out_depth_r;

  assign sts.off_done = (lv_r == mip_r);

  // Level offset: one level's area per cycle
  logic [SIDE_W-1:0]   lw_cur, lh_cur, lw, lh;
  logic [2*SIDE_W-1:0] off_prod;
  assign lw_cur   = at_least_one(side_w >> lv_r);
  assign lh_cur   = at_least_one(side_h >> lv_r);
  assign lw       = at_least_one(side_w >> mip_r);
  assign lh       = at_least_one(side_h >> mip_r);
  assign off_prod = (2*SIDE_W)'(lw_cur) * (2*SIDE_W)'(lh_cur);

  // Corner index: (c * size) >> 16, limited to size - 1
  logic [SIDE_W-1:0]  idx_size, idx_val;
  logic [PROD_W-1:0]  idx_prod;
  logic [SIDE_W:0]    idx_raw;
  assign idx_size = cmd.step[1] ? lh : lw;
  assign idx_prod = PROD_W'(cu_r[cmd.step]) * PROD_W'(idx_size);
  assign idx_raw  = idx_prod[PROD_W-1:16];
  assign idx_val  = (idx_raw >= {1'b0, idx_size}) ? idx_size - SIDE_W'(1)
                                                  : idx_raw[SIDE_W-1:0];

  logic [2*SIDE_W-1:0] row_prod;
  assign row_prod = (2*SIDE_W)'(xy_r[{1'b1, cmd.step[0]}]) * (2*SIDE_W)'(lw);

  // Corner address; step[1] picks the row, step[0] the column
  logic [RADDR_W-1:0] rd_addr;
  logic [RA_W-1:0]    rd_addr_ext;
  logic               rd_oor;
  assign rd_addr     = offset_r + RADDR_W'(row_r[cmd.step[1]])
                     + RADDR_W'(xy_r[{1'b0, cmd.step[0]}]);
  assign rd_addr_ext = RA_W'(rd_addr);
  assign rd_oor      = 64'(rd_addr) >= 64'(STORE_WORDS);

  logic [WA_W-1:0]       wr_addr_ext;
  logic                  wr_en;
  logic [DEPTH_BITS-1:0] rdata, fold_val;
  assign wr_addr_ext = WA_W'(write_address);
  assign wr_en       = cmd.wr && (64'(write_address) < 64'(STORE_WORDS));
  assign fold_val    = oor_r ? '0 : rdata;

  hfds_ram #(
    .WIDTH (DEPTH_BITS),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr_ext[AW-1:0]),
    .wdata (DEPTH_BITS'(write_depth)),
    .re    (cmd.rd_issue),
    .raddr (rd_addr_ext[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mip_r    <= (rect_level >= lvl_cnt_r) ? lvl_cnt_r - LEVEL_W'(1) : rect_level;
      lv_r     <= '0;
      offset_r <= '0;
      cu_r[0]  <= uv_clamp(rect_min_u);
      cu_r[1]  <= uv_clamp(rect_max_u);
      cu_r[2]  <= uv_clamp(rect_min_v);
      cu_r[3]  <= uv_clamp(rect_max_v);
      // untestable or empty pyramid answers 1.0
      best_r   <= sts.bypass ? '1 : '0;
    end
    if (cmd.off_step) begin
      lv_r     <= lv_r + LEVEL_W'(1);
      offset_r <= offset_r + RADDR_W'(off_prod);
    end
    if (cmd.idx_step) begin
      xy_r[cmd.step] <= idx_val;
    end
    if (cmd.row_step) begin
      row_r[cmd.step[0]] <= row_prod;
    end
    if (cmd.rd_issue) begin
      oor_r <= rd_oor;
    end
    if (cmd.fold && fold_val > best_r) begin
      best_r <= fold_val;
    end
    if (cmd.out_load) begin
      out_depth_r <= DEPTH_W'(best_r);
    end
  end

  assign farthest_depth = out_depth_r;

  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.off_step |-> (lv_r != mip_r))
    else $error("level offset summed past the selected level");

  a_fold_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fold |-> $past(cmd.rd_issue))
    else $error("store data folded without a read");

endmodule

[rtl/hiz_farthest_depth_sample_core.sv]
// Channel   Dir  Handshake          Carries
// in_req    in   valid/ready        req_type, write_address, write_depth, rect_*
// out_res   out  valid/ready        farthest_depth (one per query item, none per write)
// cfg_*     in   cfg_wr_en strobe   base_width, base_height, level_count
//
// Write item: store written at the accepting edge.
// Query item: the level offset takes one shared 9x9 product per level below the
//   clamped mip, then four reads on the store's single read port. Empty pyramid
//   or untestable rectangle: no store reads, the all-ones result is loaded directly.
// One item in flight; the next is taken while a result waits on a stalled out_res.
// rst_n synchronous, clears configuration and control; store contents undefined.
module hiz_farthest_depth_sample_core import hfds_pkg::*; #(
  parameter int MAX_SIDE    = MAX_SIDE_DEF,
  parameter int STORE_WORDS = STORE_WORDS_DEF,
  parameter int DEPTH_BITS  = DEPTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hfds_req_if.sink              in_req,
  hfds_res_if.source            out_res,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  hfds_cmd_t cmd;
  hfds_sts_t sts;

  hfds_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_is_write (in_req.req_type),
    .in_ready    (in_req.ready),
    .out_valid   (out_res.valid),
    .out_ready   (out_res.ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  hfds_dp #(
    .MAX_SIDE    (MAX_SIDE),
    .STORE_WORDS (STORE_WORDS),
    .DEPTH_BITS  (DEPTH_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .sts            (sts),
    .write_address  (in_req.write_address),
    .write_depth    (in_req.write_depth),
    .rect_min_u     (in_req.rect_min_u),
    .rect_max_u     (in_req.rect_max_u),
    .rect_min_v     (in_req.rect_min_v),
    .rect_max_v     (in_req.rect_max_v),
    .rect_level     (in_req.rect_level),
    .rect_testable  (in_req.rect_testable),
    .farthest_depth (out_res.farthest_depth)
  );

endmodule

[dv/hiz_farthest_depth_sample_core_tb.sv]
module hiz_farthest_depth_sample_core_tb import hfds_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_QUERY = 1'b0;
  localparam logic REQ_WRITE = 1'b1;
  localparam logic [DEPTH_W-1:0] DEPTH_FAR = '1;
  localparam int SETTLE_CYCLES    = 40;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int MAX_REPORTS      = 50;

  typedef struct packed {
    logic                   req_type;
    logic [ADDR_W-1:0]      write_address;
    logic [DEPTH_W-1:0]     write_depth;
    logic signed [UV_W-1:0] rect_min_u;
    logic signed [UV_W-1:0] rect_max_u;
    logic signed [UV_W-1:0] rect_min_v;
    logic signed [UV_W-1:0] rect_max_v;
    logic [LEVEL_W-1:0]     rect_level;
    logic                   rect_testable;
  } depth_req_t;

  class farthest_depth_board;
    logic [DEPTH_W-1:0] texels [STORE_WORDS_DEF];
    logic [DEPTH_W-1:0] due_depths [$];
    int unsigned base_w, base_h, levels;
    int errors;

    function void set_geometry(int unsigned w, int unsigned h, int unsigned lc);
      base_w = w & 32'h1ff;
      base_h = h & 32'h1ff;
      levels = lc & 32'hf;
    endfunction

    function int unsigned level_side(int unsigned s, int unsigned lv);
      return ((s >> lv) == 0) ? 1 : (s >> lv);
    endfunction

    // clamp to [0,1] in Q.16, scale by the level side, truncate
    function int unsigned texel_index(logic signed [UV_W-1:0] c, int unsigned size);
      int cv;
      longint unsigned idx;
      cv = int'(c);
      if (cv < 0) cv = 0;
      if (cv > int'(UV_ONE)) cv = int'(UV_ONE);
      idx = (longint'(cv) * size) >> 16;
      return (idx >= size) ? size - 1 : int'(idx);
    endfunction

    // returns 0 when the store is not read: no pyramid or rectangle not testable
    function bit corner_addresses(depth_req_t r, output int unsigned addr [4]);
      int unsigned w, h, mip, lw, lh, offset, lv;
      int unsigned xs [2], ys [2];
      w = (base_w > MAX_SIDE_DEF) ? MAX_SIDE_DEF : base_w;
      h = (base_h > MAX_SIDE_DEF) ? MAX_SIDE_DEF : base_h;
      if (levels == 0 || w == 0 || h == 0 || !r.rect_testable) return 1'b0;
      mip = (r.rect_level >= levels) ? levels - 1 : r.rect_level;
      offset = 0;
      for (lv = 0; lv < mip; lv++) offset += level_side(w, lv) * level_side(h, lv);
      lw = level_side(w, mip);
      lh = level_side(h, mip);
      xs[0] = texel_index(r.rect_min_u, lw);
      xs[1] = texel_index(r.rect_max_u, lw);
      ys[0] = texel_index(r.rect_min_v, lh);
      ys[1] = texel_index(r.rect_max_v, lh);
      foreach (addr[k]) addr[k] = offset + ys[k / 2] * lw + xs[k % 2];
      return 1'b1;
    endfunction

    function void take_item(depth_req_t r);
      int unsigned addr [4];
      logic [DEPTH_W-1:0] far;
      if (r.req_type == REQ_WRITE) begin
        texels[r.write_address] = r.write_depth;
        return;
      end
      if (!corner_addresses(r, addr)) begin
        far = DEPTH_FAR;
      end else begin
        far = '0;
        foreach (addr[k]) if (texels[addr[k]] > far) far = texels[addr[k]];
      end
      due_depths.push_back(far);
    endfunction

    function int pending();
      return due_depths.size();
    endfunction

    task report_mismatch(string what, logic [DEPTH_W-1:0] got, logic [DEPTH_W-1:0] want);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t mismatch %s: got %06h want %06h", $time, what, got, want);
    endtask

    task check_depth(logic [DEPTH_W-1:0] got);
      logic [DEPTH_W-1:0] want;
      if (due_depths.size() == 0) begin
        report_mismatch("result with nothing outstanding", got, 'x);
      end else begin
        want = due_depths.pop_front();
        if (got !== want) report_mismatch("farthest_depth", got, want);
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hfds_req_if req_if ();
  hfds_res_if res_if ();

  farthest_depth_board board = new();
  bit loaded [STORE_WORDS_DEF];
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_token     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int items_sent     = 0;

  hiz_farthest_depth_sample_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_if),
    .out_res   (res_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin : watch_in
    depth_req_t seen;
    if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
      seen.req_type      = req_if.req_type;
      seen.write_address = req_if.write_address;
      seen.write_depth   = req_if.write_depth;
      seen.rect_min_u    = req_if.rect_min_u;
      seen.rect_max_u    = req_if.rect_max_u;
      seen.rect_min_v    = req_if.rect_min_v;
      seen.rect_max_v    = req_if.rect_max_v;
      seen.rect_level    = req_if.rect_level;
      seen.rect_testable = req_if.rect_testable;
      board.take_item(seen);
    end
  end

  // result side: check, then choose ready for the next cycle
  always @(posedge clk) begin
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) board.check_depth(res_if.farthest_depth);
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic signed [UV_W-1:0] pick_uv();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return UV_W'($urandom_range(0, 65536));
    if (roll < 65) begin
      case ($urandom_range(2))
        0:       return '0;
        1:       return UV_W'(65535);
        default: return UV_W'(65536);
      endcase
    end
    if (roll < 75) return UV_W'($urandom_range(65537, 1048575));
    if (roll < 85) return UV_W'(-$urandom_range(1, 1048576));
    return UV_W'($urandom);
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_depth();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return DEPTH_FAR;
    return DEPTH_W'($urandom);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    if ($urandom_range(1)) return ADDR_W'($urandom_range(0, 400));
    return ADDR_W'($urandom);
  endfunction

  // every field but req_type (query) random; the fields the item type ignores stay random too
  function automatic depth_req_t random_item();
    depth_req_t r;
    r.req_type      = REQ_QUERY;
    r.write_address = ADDR_W'($urandom);
    r.write_depth   = DEPTH_W'($urandom);
    r.rect_min_u    = UV_W'($urandom);
    r.rect_max_u    = UV_W'($urandom);
    r.rect_min_v    = UV_W'($urandom);
    r.rect_max_v    = UV_W'($urandom);
    r.rect_level    = LEVEL_W'($urandom);
    r.rect_testable = 1'($urandom);
    return r;
  endfunction

  function automatic depth_req_t random_query();
    depth_req_t q;
    q = random_item();
    q.rect_min_u = pick_uv();
    q.rect_max_u = pick_uv();
    q.rect_min_v = pick_uv();
    q.rect_max_v = pick_uv();
    if ($urandom_range(99) < 40) q.rect_level = LEVEL_W'($urandom_range(0, board.levels));
    q.rect_testable = ($urandom_range(99) < 90);
    return q;
  endfunction

  function automatic depth_req_t full_rect(int unsigned level);
    depth_req_t q;
    q = random_item();
    q.rect_min_u    = '0;
    q.rect_max_u    = UV_W'(65536);
    q.rect_min_v    = '0;
    q.rect_max_v    = UV_W'(65536);
    q.rect_level    = LEVEL_W'(level);
    q.rect_testable = 1'b1;
    return q;
  endfunction

  task automatic push_item(input depth_req_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.req_type      <= it.req_type;
    req_if.write_address <= it.write_address;
    req_if.write_depth   <= it.write_depth;
    req_if.rect_min_u    <= it.rect_min_u;
    req_if.rect_max_u    <= it.rect_max_u;
    req_if.rect_min_v    <= it.rect_min_v;
    req_if.rect_max_v    <= it.rect_max_v;
    req_if.rect_level    <= it.rect_level;
    req_if.rect_testable <= it.rect_testable;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic push_write(input logic [ADDR_W-1:0] addr, input logic [DEPTH_W-1:0] depth);
    depth_req_t it;
    it = random_item();
    it.req_type      = REQ_WRITE;
    it.write_address = addr;
    it.write_depth   = depth;
    loaded[addr] = 1'b1;
    push_item(it);
  endtask

  // texels are loaded before any query may read them
  task automatic push_query(input depth_req_t q);
    int unsigned corner [4];
    if (board.corner_addresses(q, corner))
      foreach (corner[k])
        if (!loaded[corner[k]]) push_write(ADDR_W'(corner[k]), pick_depth());
    push_item(q);
  endtask

  // one edge first so the last accepted item is already on the board
  task automatic settle();
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_geometry(input int unsigned w, input int unsigned h,
                               input int unsigned lc);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_BASE_WIDTH;
    cfg_wdata <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= CFG_BASE_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_index <= CFG_LEVEL_COUNT;
    cfg_wdata <= CFG_DATA_W'(lc);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_geometry(w, h, lc);
  endtask

  // n counts every item sent, texel loads included
  task automatic run_phase(input int n, input int unsigned w, input int unsigned h,
                           input int unsigned lc, input int send_pct, input int recv_pct,
                           input bit long_hold);
    int stop_at;
    req_if.valid <= 1'b0;
    settle();
    load_geometry(w, h, lc);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
    if (long_hold) hold_token <= hold_token + 1;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 30) push_write(pick_address(), pick_depth());
      else push_query(random_query());
    end
  endtask

  initial begin
    depth_req_t q;
    int unsigned lv;
    rst_n                <= 1'b0;
    cfg_wr_en            <= 1'b0;
    cfg_index            <= CFG_BASE_WIDTH;
    cfg_wdata            <= '0;
    req_if.valid         <= 1'b0;
    req_if.req_type      <= REQ_QUERY;
    req_if.write_address <= '0;
    req_if.write_depth   <= '0;
    req_if.rect_min_u    <= '0;
    req_if.rect_max_u    <= '0;
    req_if.rect_min_v    <= '0;
    req_if.rect_max_v    <= '0;
    req_if.rect_level    <= '0;
    req_if.rect_testable <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // out of reset there is no pyramid: every query gives all ones
    push_write('0, '0);
    push_write('1, DEPTH_FAR);
    push_query(full_rect(0));
    push_query(full_rect(9));

    req_if.valid <= 1'b0;
    settle();
    load_geometry(256, 256, 9);
    for (lv = 0; lv < 16; lv++) push_query(full_rect(lv));
    q = full_rect(0);
    q.rect_min_u = 21'sh100000;
    q.rect_max_u = 21'sh0fffff;
    q.rect_min_v = 21'sh100000;
    q.rect_max_v = 21'sh0fffff;
    push_query(q);
    // just under one must truncate to the last texel
    q = full_rect(3);
    q.rect_min_u = UV_W'(65535);
    q.rect_max_u = UV_W'(65535);
    q.rect_min_v = UV_W'(32768);
    q.rect_max_v = UV_W'(1);
    push_query(q);
    q = full_rect(2);
    q.rect_testable = 1'b0;
    push_query(q);
    q = full_rect(0);
    q.rect_max_u = '0;
    q.rect_max_v = '0;
    push_write('0, DEPTH_FAR);
    push_query(q);
    push_write('0, '0);
    push_query(q);

    run_phase(150, 256, 256, 9, 0, 0, 1'b0);
    run_phase(150, 511, 511, 15, 50, 0, 1'b0);
    run_phase(120, 1, 1, 1, 0, 50, 1'b1);
    run_phase(80, 0, 64, 5, 16, 16, 1'b0);
    run_phase(80, 64, 0, 4, 0, 0, 1'b0);
    run_phase(80, 100, 37, 0, 50, 0, 1'b0);
    run_phase(120, 256, 1, 9, 0, 50, 1'b0);
    run_phase(120, 3, 200, 15, 16, 16, 1'b0);
    run_phase(150, $urandom_range(1, 511), $urandom_range(1, 511), $urandom_range(1, 15),
              0, 0, 1'b1);
    run_phase(150, $urandom_range(1, 511), $urandom_range(1, 511), $urandom_range(1, 15),
              16, 16, 1'b0);
    run_phase(150, 256, 256, 9, 0, 50, 1'b0);

    req_if.valid <= 1'b0;
    settle();
    if (board.errors == 0) begin
      $display("hiz_farthest_depth_sample_core_tb: done, clean");
    end else begin
      $display("hiz_farthest_depth_sample_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("hiz_farthest_depth_sample_core_tb: done, errors");
    $finish;
  end

endmodule
